FILE: rtl/ddst_pkg.sv
`default_nettype none
package ddst_pkg;

	// command codes
	localparam logic [2:0] CMD_INIT      = 3'd0;
	localparam logic [2:0] CMD_REPORT    = 3'd1;
	localparam logic [2:0] CMD_READ      = 3'd2;
	localparam logic [2:0] CMD_CYC_START = 3'd3;
	localparam logic [2:0] CMD_CYC_END   = 3'd4;
	localparam logic [2:0] CMD_CLR_HEAL  = 3'd5;

	// report status codes
	localparam logic [1:0] ES_PASSED    = 2'd0;
	localparam logic [1:0] ES_FAILED    = 2'd1;
	localparam logic [1:0] ES_PREPASSED = 2'd2;
	localparam logic [1:0] ES_PREFAILED = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_FAIL_THRESHOLD   = 2'd0;
	localparam logic [1:0] CFG_DEFAULT_STATUS   = 2'd1;
	localparam logic [1:0] CFG_INVALID_EVENT_ID = 2'd2;

	// status byte bits
	localparam logic [7:0] ST_TF     = 8'h01;
	localparam logic [7:0] ST_TFTOC  = 8'h02;
	localparam logic [7:0] ST_PDTC   = 8'h04;
	localparam logic [7:0] ST_CDTC   = 8'h08;
	localparam logic [7:0] ST_TNCSLC = 8'h10;
	localparam logic [7:0] ST_TFSLC  = 8'h20;
	localparam logic [7:0] ST_TNCTOC = 8'h40;
	localparam logic [7:0] ST_WIR    = 8'h80;

	localparam logic [14:0] CNT_MAX = 15'h7FFF;

	typedef struct packed {
		logic [14:0] count;
		logic [7:0]  status;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic rd_one;
		logic wr_one;
		logic rd_sweep;
		logic wr_sweep;
		logic init_wr;
		logic respond;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] cmd;
		logic       usable;
		logic       in_range;
		logic       sweep_last;
	} dp_sts_t;

endpackage
`default_nettype wire

FILE: rtl/ddst_ctrl.sv
`default_nettype none
module ddst_ctrl
	import ddst_pkg::*;
(
	input  wire      clk,
	input  wire      arst_n,
	input  wire      start,
	input  wire dp_sts_t sts,
	output ctl_cmd_t ctl,
	output logic     busy
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_WR   = 3'd3;
	localparam logic [2:0] S_SRD  = 3'd4;
	localparam logic [2:0] S_SWR  = 3'd5;
	localparam logic [2:0] S_INIT = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				case (sts.cmd) inside
					CMD_INIT: state_d = S_INIT;
					CMD_REPORT, CMD_READ: begin
						if (sts.usable) begin
							state_d = S_RD;
						end else begin
							ctl.respond = 1'b1;
							state_d     = S_IDLE;
						end
					end
					CMD_CLR_HEAL: begin
						if (sts.in_range) begin
							state_d = S_RD;
						end else begin
							ctl.respond = 1'b1;
							state_d     = S_IDLE;
						end
					end
					CMD_CYC_START, CMD_CYC_END: state_d = S_SRD;
					default: begin
						ctl.respond = 1'b1;
						state_d     = S_IDLE;
					end
				endcase
			end
			S_RD: begin
				ctl.rd_one = 1'b1;
				state_d    = S_WR;
			end
			S_WR: begin
				ctl.wr_one  = (sts.cmd == CMD_REPORT) || (sts.cmd == CMD_CLR_HEAL);
				ctl.respond = 1'b1;
				state_d     = S_IDLE;
			end
			S_SRD: begin
				ctl.rd_sweep = 1'b1;
				state_d      = S_SWR;
			end
			S_SWR: begin
				ctl.wr_sweep = 1'b1;
				if (sts.sweep_last) begin
					ctl.respond = 1'b1;
					state_d     = S_IDLE;
				end else begin
					state_d = S_SRD;
				end
			end
			S_INIT: begin
				ctl.init_wr = 1'b1;
				if (sts.sweep_last) begin
					ctl.respond = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

FILE: rtl/ddst_dpath.sv
`default_nettype none
module ddst_dpath
	import ddst_pkg::*;
#(
	parameter int NUM_EVENTS = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_idx,
	input  wire  [14:0] cfg_data,
	input  wire  [2:0]  command,
	input  wire  [7:0]  event_id,
	input  wire  [1:0]  event_status,
	input  wire ctl_cmd_t ctl,
	output dp_sts_t     sts,
	output logic        done,
	output logic        ok,
	output logic [7:0]  status_byte
);

	localparam int IDW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
	localparam logic [8:0] NUM_EV9 = 9'(NUM_EVENTS);
	localparam logic [IDW-1:0] LAST_IDX = IDW'(NUM_EVENTS - 1);

	// configuration
	logic [14:0] thr_q;
	logic [7:0]  dflt_q;
	logic [7:0]  bad_id_q;

	// captured command word
	logic [2:0] cmd_q;
	logic [7:0] id_q;
	logic [1:0] es_q;

	logic                  ready_q;
	logic [NUM_EVENTS-1:0] active_q;
	logic [IDW-1:0]        sweep_q;

	entry_t entry_mem_q [NUM_EVENTS];
	entry_t rdata_q;

	logic           in_range;
	logic           usable;
	logic [IDW-1:0] id_idx;
	logic [IDW-1:0] addr;
	logic           mem_we;
	entry_t         wdata;
	entry_t         one_wdata;
	entry_t         sweep_wdata;
	logic [14:0]    cnt_inc;
	logic [14:0]    cnt_dec;
	logic [14:0]    new_cnt;
	logic           fail_hit;
	logic           pass_hit;
	logic [7:0]     rep_status;
	logic           ok_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= 15'd3;
			dflt_q   <= 8'd80;
			bad_id_q <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_FAIL_THRESHOLD:   thr_q    <= cfg_data;
				CFG_DEFAULT_STATUS:   dflt_q   <= cfg_data[7:0];
				CFG_INVALID_EVENT_ID: bad_id_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= command;
			id_q  <= event_id;
			es_q  <= event_status;
		end
	end

	assign in_range = {1'b0, id_q} < NUM_EV9;
	assign usable   = ready_q && (id_q != bad_id_q) && in_range;
	assign id_idx   = id_q[IDW-1:0];

	assign sts.cmd        = cmd_q;
	assign sts.usable     = usable;
	assign sts.in_range   = in_range;
	assign sts.sweep_last = (sweep_q == LAST_IDX);

	// sweep index for init and operation cycle passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (ctl.load) begin
			sweep_q <= '0;
		end else if (ctl.init_wr || ctl.wr_sweep) begin
			sweep_q <= sweep_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q  <= 1'b0;
			active_q <= '0;
		end else begin
			if (ctl.init_wr) begin
				active_q[sweep_q] <= 1'b0;
				if (sweep_q == LAST_IDX) begin
					ready_q <= 1'b1;
				end
			end else if (ctl.wr_one && (cmd_q == CMD_REPORT)) begin
				active_q[id_idx] <= 1'b1;
			end
		end
	end

	// report debounce
	assign cnt_inc  = (rdata_q.count == CNT_MAX) ? rdata_q.count : rdata_q.count + 15'd1;
	assign cnt_dec  = (rdata_q.count == 15'd0) ? rdata_q.count : rdata_q.count - 15'd1;
	assign new_cnt  = es_q[0] ? cnt_inc : cnt_dec;
	assign fail_hit = (es_q == ES_FAILED) && (new_cnt >= thr_q);
	assign pass_hit = (es_q == ES_PASSED) && (new_cnt == 15'd0);

	always_comb begin
		rep_status = rdata_q.status;
		if (fail_hit) begin
			rep_status = (rdata_q.status | ST_TF | ST_TFTOC | ST_PDTC | ST_CDTC | ST_TFSLC)
				& ~ST_TNCTOC;
		end else if (pass_hit) begin
			rep_status = rdata_q.status & ~(ST_TF | ST_TFTOC | ST_PDTC);
		end
	end

	always_comb begin
		if (cmd_q == CMD_REPORT) begin
			one_wdata.count  = new_cnt;
			one_wdata.status = rep_status;
		end else begin
			one_wdata.count  = rdata_q.count;
			one_wdata.status = rdata_q.status & ~(ST_TNCSLC | ST_WIR);
		end
	end

	always_comb begin
		sweep_wdata.count = rdata_q.count;
		if (cmd_q == CMD_CYC_START) begin
			sweep_wdata.status = (rdata_q.status | ST_TNCTOC) & ~ST_TFTOC;
		end else begin
			sweep_wdata.status = rdata_q.status & ~ST_TFTOC;
		end
	end

	always_comb begin
		if (ctl.init_wr) begin
			wdata.count  = '0;
			wdata.status = dflt_q;
		end else if (ctl.wr_sweep) begin
			wdata = sweep_wdata;
		end else begin
			wdata = one_wdata;
		end
	end

	assign addr   = (ctl.rd_one || ctl.wr_one) ? id_idx : sweep_q;
	assign mem_we = ctl.wr_one || ctl.init_wr || (ctl.wr_sweep && active_q[sweep_q]);

	// entry table: one write or one read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem_q[addr] <= wdata;
		end
		if (ctl.rd_one || ctl.rd_sweep) begin
			rdata_q <= entry_mem_q[addr];
		end
	end

	always_comb begin
		case (cmd_q) inside
			CMD_INIT, CMD_CYC_START, CMD_CYC_END: ok_d = 1'b1;
			CMD_REPORT, CMD_READ:                 ok_d = usable;
			CMD_CLR_HEAL:                         ok_d = in_range;
			default:                              ok_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl.respond;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.respond) begin
			ok          <= ok_d;
			status_byte <= ((cmd_q == CMD_READ) && usable) ? rdata_q.status : 8'd0;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/diag_event_debounce_status_table.sv
`default_nettype none
// channel  | ports                                   | handshake
// ---------+-----------------------------------------+-------------------------------
// command  | command, event_id, event_status         | taken when start && !busy
// result   | ok, status_byte                         | one-cycle strobe on done
// config   | cfg_idx, cfg_data                       | written when cfg_we is high
//
// read, report and clear healing step from decode to an entry read, then to a write
// state that writes the entry back for report and clear healing; done is registered
// from that state. rejected commands respond from decode. init walks the table one
// entry a cycle; cycle start/end read each entry and write back the active ones.
// reset clears flags and ready and sets config defaults; init loads the table.
// done is not held: the receiver cannot stall.
module diag_event_debounce_status_table
	import ddst_pkg::*;
#(
	parameter int NUM_EVENTS = 64
) (
	input  wire        clk,
	input  wire        arst_n,
	// configuration write port
	input  wire        cfg_we,
	input  wire  [1:0] cfg_idx,
	input  wire [14:0] cfg_data,
	// command word
	input  wire        start,
	output logic       busy,
	input  wire  [2:0] command,
	input  wire  [7:0] event_id,
	input  wire  [1:0] event_status,
	// result word
	output logic       done,
	output logic       ok,
	output logic [7:0] status_byte
);

	// command and status between sequencer and datapath
	ctl_cmd_t ctl;
	dp_sts_t  sts;

	// sequencer: decode, single entry read-modify-write, table sweeps
	ddst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	// datapath: config registers, entry table, active flags, debounce logic
	ddst_dpath #(
		.NUM_EVENTS (NUM_EVENTS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.command      (command),
		.event_id     (event_id),
		.event_status (event_status),
		.ctl          (ctl),
		.sts          (sts),
		.done         (done),
		.ok           (ok),
		.status_byte  (status_byte)
	);

endmodule
`default_nettype wire

FILE: sim/ddst_result_checker.sv
module ddst_result_checker
	import ddst_pkg::*;
#(
	parameter int NUM_EVENTS = 64
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire  [1:0] cfg_idx,
	input  wire [14:0] cfg_data,
	input  wire        start,
	input  wire        busy,
	input  wire  [2:0] command,
	input  wire  [7:0] event_id,
	input  wire  [1:0] event_status,
	input  wire        done,
	input  wire        ok,
	input  wire  [7:0] status_byte,
	output int         fail_count,
	output int         outstanding
);

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] id;
		logic       ok;
		logic [7:0] sb;
	} word_exp_t;

	// shadow copy of the event table and its registers
	logic [14:0] fault_cnt [NUM_EVENTS];
	logic [7:0]  uds_sts   [NUM_EVENTS];
	logic        entry_on  [NUM_EVENTS];
	logic        table_up;
	logic [14:0] fail_thr;
	logic [7:0]  init_sts;
	logic [7:0]  reject_id;

	word_exp_t expected_q[$];
	int        n_fail;

	task automatic predict_result(input logic [2:0] cmd, input logic [7:0] id,
		input logic [1:0] es, output word_exp_t w);
		logic [14:0] c;
		logic [7:0]  s;
		logic        usable;
		int          i;
		w.cmd = cmd;
		w.id  = id;
		w.ok  = 1'b0;
		w.sb  = 8'h00;
		usable = table_up && (id != reject_id) && (int'(id) < NUM_EVENTS);
		case (cmd)
			CMD_INIT: begin
				for (i = 0; i < NUM_EVENTS; i++) begin
					fault_cnt[i] = '0;
					entry_on[i]  = 1'b0;
					uds_sts[i]   = init_sts;
				end
				table_up = 1'b1;
				w.ok = 1'b1;
			end
			CMD_REPORT: begin
				if (usable) begin
					c = fault_cnt[id];
					s = uds_sts[id];
					entry_on[id] = 1'b1;
					if (es == ES_FAILED || es == ES_PREFAILED) begin
						if (c != CNT_MAX)
							c = c + 15'd1;
					end else if (c != '0) begin
						c = c - 15'd1;
					end
					fault_cnt[id] = c;
					if (es == ES_FAILED && c >= fail_thr) begin
						s = s | ST_TF | ST_TFTOC | ST_PDTC | ST_CDTC | ST_TFSLC;
						s = s & ~ST_TNCTOC;
					end else if (es == ES_PASSED && c == '0) begin
						s = s & ~(ST_TF | ST_TFTOC | ST_PDTC);
					end
					uds_sts[id] = s;
					w.ok = 1'b1;
				end
			end
			CMD_READ: begin
				if (usable) begin
					w.sb = uds_sts[id];
					w.ok = 1'b1;
				end
			end
			CMD_CYC_START: begin
				for (i = 0; i < NUM_EVENTS; i++)
					if (entry_on[i])
						uds_sts[i] = (uds_sts[i] | ST_TNCTOC) & ~ST_TFTOC;
				w.ok = 1'b1;
			end
			CMD_CYC_END: begin
				for (i = 0; i < NUM_EVENTS; i++)
					if (entry_on[i])
						uds_sts[i] = uds_sts[i] & ~ST_TFTOC;
				w.ok = 1'b1;
			end
			CMD_CLR_HEAL: begin
				// no ready or invalid id check here
				if (int'(id) < NUM_EVENTS) begin
					uds_sts[id] = uds_sts[id] & ~(ST_TNCSLC | ST_WIR);
					w.ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		word_exp_t oldest;
		word_exp_t fresh;
		int        i;
		if (!arst_n) begin
			for (i = 0; i < NUM_EVENTS; i++) begin
				fault_cnt[i] = '0;
				uds_sts[i]   = '0;
				entry_on[i]  = 1'b0;
			end
			table_up  = 1'b0;
			fail_thr  = 15'd3;
			init_sts  = 8'd80;
			reject_id = 8'd0;
			expected_q.delete();
			n_fail = 0;
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_FAIL_THRESHOLD:   fail_thr  = cfg_data;
					CFG_DEFAULT_STATUS:   init_sts  = cfg_data[7:0];
					CFG_INVALID_EVENT_ID: reject_id = cfg_data[7:0];
					default: begin
					end
				endcase
			end
			// result first: it belongs to an older word than one taken now
			if (done) begin
				if (expected_q.size() == 0) begin
					if (n_fail < 10)
						$display("unexpected result word: ok %0b status %02h", ok, status_byte);
					n_fail++;
				end else begin
					oldest = expected_q.pop_front();
					if (ok !== oldest.ok || status_byte !== oldest.sb) begin
						if (n_fail < 10)
							$display("mismatch cmd %0d id %0d: ok exp %0b got %0b, status exp %02h got %02h",
								oldest.cmd, oldest.id, oldest.ok, ok, oldest.sb, status_byte);
						n_fail++;
					end
				end
			end
			if (start && !busy) begin
				predict_result(command, event_id, event_status, fresh);
				expected_q.push_back(fresh);
			end
			fail_count  <= n_fail;
			outstanding <= expected_q.size();
		end
	end

endmodule

FILE: sim/tb_diag_event_debounce_status_table.sv
module tb_diag_event_debounce_status_table;
	import ddst_pkg::*;

	localparam int NUM_EVENTS = 64;
	// cycles with no accept and no result before the run is declared hung
	localparam int QUIET_LIMIT = 4000;
	// unused command codes, rejected by the block
	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic  [1:0] cfg_idx = '0;
	logic [14:0] cfg_data = '0;
	logic        start = 1'b0;
	logic  [2:0] command = '0;
	logic  [7:0] event_id = '0;
	logic  [1:0] event_status = '0;
	logic        busy;
	logic        done;
	logic        ok;
	logic  [7:0] status_byte;

	int fail_count;
	int outstanding;
	int quiet_cycles = 0;
	// percent chance per cycle that the sender holds back
	int idle_pct = 0;
	// invalid id currently programmed, so random ids can aim at it
	logic [7:0] cur_bad = '0;

	always #5 clk = ~clk;

	diag_event_debounce_status_table #(
		.NUM_EVENTS(NUM_EVENTS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.event_id     (event_id),
		.event_status (event_status),
		.done         (done),
		.ok           (ok),
		.status_byte  (status_byte)
	);

	ddst_result_checker #(
		.NUM_EVENTS(NUM_EVENTS)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.event_id     (event_id),
		.event_status (event_status),
		.done         (done),
		.ok           (ok),
		.status_byte  (status_byte),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	// watchdog: any accepted word on either side restarts the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// present one command word and hold it until the block takes it
	task automatic send_word(input logic [2:0] cmd, input logic [7:0] id,
		input logic [1:0] es);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < idle_pct);
		end
		start        <= 1'b1;
		command      <= cmd;
		event_id     <= id;
		event_status <= es;
		// busy is sampled before the edge updates land, so this sees the accept edge
		do
			@(posedge clk);
		while (busy);
	endtask

	// stop sending and let every expected result come back
	task automatic wait_quiet();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		while (busy)
			@(posedge clk);
		// slack for work with no result word still in flight
		repeat (4) @(posedge clk);
	endtask

	// program all three registers, one per cycle; only called with the block idle
	task automatic set_regs(input logic [14:0] thr, input logic [7:0] dflt,
		input logic [7:0] bad);
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_FAIL_THRESHOLD;
		cfg_data <= thr;
		@(posedge clk);
		cfg_idx  <= CFG_DEFAULT_STATUS;
		cfg_data <= {7'd0, dflt};
		@(posedge clk);
		cfg_idx  <= CFG_INVALID_EVENT_ID;
		cfg_data <= {7'd0, bad};
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_bad = bad;
	endtask

	// ids mostly from a small hot set so counters climb past the threshold
	function automatic logic [7:0] pick_id();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return cur_bad;
		else if (r < 75)
			return 8'($urandom_range(0, 7));
		else if (r < 90)
			return 8'($urandom_range(0, NUM_EVENTS - 1));
		else
			return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [1:0] pick_status();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return ES_FAILED;
		else if (r < 70)
			return ES_PASSED;
		else if (r < 85)
			return ES_PREFAILED;
		else
			return ES_PREPASSED;
	endfunction

	// one register setting, one idle profile, a fresh init, then random traffic
	task automatic run_phase(input logic [14:0] thr, input logic [7:0] dflt,
		input logic [7:0] bad, input int pct, input int n_words);
		int r;
		set_regs(thr, dflt, bad);
		idle_pct = pct;
		send_word(CMD_INIT, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
		repeat (n_words) begin
			r = $urandom_range(0, 99);
			if (r < 50)
				send_word(CMD_REPORT, pick_id(), pick_status());
			else if (r < 75)
				send_word(CMD_READ, pick_id(), 2'($urandom_range(0, 3)));
			else if (r < 81)
				send_word(CMD_CLR_HEAL, pick_id(), 2'($urandom_range(0, 3)));
			else if (r < 85)
				send_word(CMD_CYC_START, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
			else if (r < 89)
				send_word(CMD_CYC_END, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
			else if (r < 91)
				send_word(CMD_INIT, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
			else if (r < 94)
				send_word($urandom_range(0, 1) ? CMD_SPARE_B : CMD_SPARE_A,
					8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
			else
				send_word(CMD_REPORT, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
			// now and then hold off until the table has answered everything
			if ($urandom_range(0, 149) == 0)
				wait_quiet();
		end
		wait_quiet();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_regs(15'd3, 8'd80, 8'd0);

		// before init: reads and reports are refused, sweeps and clear healing still run
		send_word(CMD_READ, 8'd1, ES_PASSED);
		send_word(CMD_REPORT, 8'd1, ES_FAILED);
		send_word(CMD_CYC_START, 8'd0, ES_PASSED);
		send_word(CMD_CYC_END, 8'd0, ES_PASSED);
		send_word(CMD_CLR_HEAL, 8'd200, ES_PASSED);
		send_word(CMD_CLR_HEAL, 8'd3, ES_PASSED);
		send_word(CMD_SPARE_A, 8'd1, ES_FAILED);
		send_word(CMD_SPARE_B, 8'd255, ES_PREFAILED);

		send_word(CMD_INIT, 8'd0, ES_PASSED);
		// invalid id, last entry, just out of range, top of the id field
		send_word(CMD_READ, 8'd0, ES_PASSED);
		send_word(CMD_READ, 8'(NUM_EVENTS - 1), ES_PASSED);
		send_word(CMD_READ, 8'(NUM_EVENTS), ES_PASSED);
		send_word(CMD_READ, 8'd255, ES_PASSED);
		// third failure reaches the threshold and sets the failure bits
		repeat (3) send_word(CMD_REPORT, 8'd1, ES_FAILED);
		send_word(CMD_READ, 8'd1, ES_PASSED);
		send_word(CMD_CYC_START, 8'd0, ES_PASSED);
		send_word(CMD_READ, 8'd1, ES_PASSED);
		send_word(CMD_REPORT, 8'd1, ES_PREFAILED);
		send_word(CMD_REPORT, 8'd1, ES_PREPASSED);
		send_word(CMD_CYC_END, 8'd0, ES_PASSED);
		send_word(CMD_CLR_HEAL, 8'd1, ES_PASSED);
		// counting back to zero clears test failed and pending
		repeat (3) send_word(CMD_REPORT, 8'd1, ES_PASSED);
		send_word(CMD_READ, 8'd1, ES_PASSED);
		// invalid id refused for report but not for clear healing
		send_word(CMD_REPORT, 8'd0, ES_FAILED);
		send_word(CMD_CLR_HEAL, 8'd0, ES_PASSED);
		// passed at zero stays at zero
		send_word(CMD_REPORT, 8'd2, ES_PASSED);
		send_word(CMD_READ, 8'd2, ES_PASSED);
		wait_quiet();

		// random phases: lowest, zero and highest thresholds, status and id extremes
		run_phase(15'd3, 8'd80, 8'd0, 0, 310);
		run_phase(15'd1, 8'd0, 8'd255, 67, 310);
		run_phase(15'd0, 8'd255, 8'(NUM_EVENTS - 1), 31, 310);
		run_phase(15'($urandom_range(2, 6)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, NUM_EVENTS - 1)), 0, 310);
		run_phase(CNT_MAX, 8'hA5, 8'(NUM_EVENTS), 67, 310);
		run_phase(15'd2, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 31, 310);

		if (fail_count == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
